/* sv/imh_pkg.sv */
// imh_pkg: shared types and constants for the indexed min-heap block.
// No dependencies; imported by indexed_min_heap_update_top.
`default_nettype none
package imh_pkg;
   localparam int MaxNodes  = 1024;
   localparam int IdWidth   = 10;
   localparam int KeyWidth  = 64;
   localparam int CntWidth  = 11;

   typedef logic [IdWidth-1:0]  id_type;
   typedef logic [KeyWidth-1:0] key_type;
   typedef logic [CntWidth-1:0] cnt_type;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_UPDATE = 2'd2,
      CMD_READ   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_RANGE  = 2'd1,
      ST_FULL   = 2'd2,
      ST_ABSENT = 2'd3
   } status_type;

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_CLEAR  = 10'b0000000010,
      S_LOOK   = 10'b0000000100,
      S_POS    = 10'b0000001000,
      S_CUR    = 10'b0000010000,
      S_NBR    = 10'b0000100000,
      S_RCH    = 10'b0001000000,
      S_DEC    = 10'b0010000000,
      S_ROOT   = 10'b0100000000,
      S_OUT    = 10'b1000000000
   } state_type;
endpackage
`default_nettype wire

/* sv/indexed_min_heap_update_top.sv */
// Indexed binary min-heap with node-to-slot position table.
// Depends on imh_pkg.
// One command at a time; req_ready stays low until the previous result transfer is done.
// Clear (and a csr_ write, which also empties the heap) runs a sweep that clears the
// presence memory one entry a cycle. Read fetches the stored key; append and update
// write the entry and then sift it up or down the heap, at most 10 levels; every
// memory port returns registered data in the cycle after its address, which sets the
// cost of each level. After reset the same clearing sweep runs before req_ready rises.
`default_nettype none
module indexed_min_heap_update_top import imh_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_we,
   input  wire logic          csr_wdata,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire logic [1:0]    req_cmd,
   input  wire logic [9:0]    req_node_id,
   input  wire logic [63:0]   req_event_key,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic [9:0]         rsp_min_node,
   output logic [63:0]        rsp_min_key,
   output logic               rsp_heap_empty,
   output logic [63:0]        rsp_read_key,
   output logic [1:0]         rsp_status
);
   // memories
   id_type  slot_node_mem [MaxNodes];
   key_type slot_key_mem  [MaxNodes];
   id_type  node_slot_mem [MaxNodes];
   logic    present_mem   [MaxNodes];

   // memory read ports (registered data)
   id_type  sn_raddr, ns_raddr, pr_raddr;
   id_type  sk_raddr;
   id_type  sn_rdata_ff, ns_rdata_ff;
   key_type sk_rdata_ff;
   logic    pr_rdata_ff;

   // write ports
   logic    sn_we, sk_we, ns_we, pr_we;
   id_type  sn_waddr, sk_waddr, ns_waddr, pr_waddr;
   id_type  sn_wdata, ns_wdata;
   key_type sk_wdata;
   logic    pr_wdata;

   always_ff @(posedge clock) begin
      if (sn_we) slot_node_mem[sn_waddr] <= sn_wdata;
      if (sk_we) slot_key_mem[sk_waddr]  <= sk_wdata;
      if (ns_we) node_slot_mem[ns_waddr] <= ns_wdata;
      if (pr_we) present_mem[pr_waddr]   <= pr_wdata;
      sn_rdata_ff <= slot_node_mem[sn_raddr];
      sk_rdata_ff <= slot_key_mem[sk_raddr];
      ns_rdata_ff <= node_slot_mem[ns_raddr];
      pr_rdata_ff <= present_mem[pr_raddr];
   end

   // control registers
   state_type state_ff, state_in;
   logic      base_ff, base_in;
   cnt_type   count_ff, count_in;
   cnt_type   sweep_ff, sweep_in;
   cmd_type   cmd_ff, cmd_in;
   id_type    id_ff, id_in;
   key_type   key_ff, key_in;       // key of the moving entry
   id_type    cur_ff, cur_in;       // slot of the moving entry
   id_type    nbr_ff, nbr_in;       // parent or chosen child slot
   id_type    nnode_ff, nnode_in;   // node at nbr
   key_type   nkey_ff, nkey_in;     // key at nbr
   logic      up_ff, up_in;         // nbr is the parent
   logic      rok_ff, rok_in;       // right child exists
   logic      rsp_valid_ff, rsp_valid_in;
   id_type    min_node_ff, min_node_in;
   key_type   min_key_ff, min_key_in;
   logic      empty_ff, empty_in;
   key_type   rkey_ff, rkey_in;
   status_type status_ff, status_in;

   // slot arithmetic on 11 bits to cover the end of the heap
   cnt_type cur_w, end_w, lc_w, rc_w, par_w;
   always_comb begin
      cur_w = {1'b0, cur_ff};
      end_w = count_ff + cnt_type'(base_ff);
      lc_w  = (cur_w << 1) + cnt_type'(1) - cnt_type'(base_ff);
      rc_w  = lc_w + cnt_type'(1);
      par_w = (cur_w + cnt_type'(base_ff) - cnt_type'(1)) >> 1;
   end

   logic id_bad;
   assign id_bad = (req_node_id < IdWidth'(base_ff));

   // next-state logic
   always_comb begin
      state_in = state_ff;   base_in = base_ff;     count_in = count_ff;
      sweep_in = sweep_ff;   cmd_in = cmd_ff;       id_in = id_ff;
      key_in = key_ff;       cur_in = cur_ff;       nbr_in = nbr_ff;
      nnode_in = nnode_ff;   nkey_in = nkey_ff;     up_in = up_ff;
      rok_in = rok_ff;       rsp_valid_in = rsp_valid_ff;
      min_node_in = min_node_ff; min_key_in = min_key_ff; empty_in = empty_ff;
      rkey_in = rkey_ff;     status_in = status_ff;
      sn_we = 1'b0; sk_we = 1'b0; ns_we = 1'b0; pr_we = 1'b0;
      sn_waddr = cur_ff; sk_waddr = cur_ff; ns_waddr = id_ff; pr_waddr = id_ff;
      sn_wdata = id_ff; sk_wdata = key_ff; ns_wdata = cur_ff; pr_wdata = 1'b1;
      sn_raddr = cur_ff; sk_raddr = cur_ff; ns_raddr = id_ff; pr_raddr = id_ff;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd_in = cmd_type'(req_cmd);
               id_in  = req_node_id;
               key_in = req_event_key;
               rkey_in = '0;
               status_in = ST_OK;
               pr_raddr = req_node_id;
               ns_raddr = req_node_id;
               if (cmd_type'(req_cmd) == CMD_CLEAR) begin
                  count_in = '0;
                  sweep_in = '0;
                  state_in = S_CLEAR;
               end else if (id_bad) begin
                  status_in = ST_RANGE;
                  state_in = S_ROOT;
               end else begin
                  state_in = S_LOOK;
               end
            end
         end
         S_CLEAR: begin
            pr_we = 1'b1;
            pr_waddr = sweep_ff[IdWidth-1:0];
            pr_wdata = 1'b0;
            sweep_in = sweep_ff + cnt_type'(1);
            if (sweep_ff == cnt_type'(MaxNodes - 1)) state_in = S_ROOT;
         end
         S_LOOK: begin
            // presence and position are ready
            priority case (cmd_ff)
               CMD_APPEND: begin
                  if (pr_rdata_ff ||
                      count_ff >= cnt_type'(MaxNodes) - cnt_type'(base_ff)) begin
                     status_in = ST_FULL;
                     state_in = S_ROOT;
                  end else begin
                     cur_in = end_w[IdWidth-1:0];
                     pr_we = 1'b1;
                     count_in = count_ff + cnt_type'(1);
                     state_in = S_POS;
                  end
               end
               default: begin
                  if (!pr_rdata_ff) begin
                     status_in = ST_ABSENT;
                     state_in = S_ROOT;
                  end else begin
                     cur_in = ns_rdata_ff;
                     sk_raddr = ns_rdata_ff;
                     state_in = S_POS;
                  end
               end
            endcase
         end
         S_POS: begin
            // entry at cur: write node, key, position (read keeps memory)
            if (cmd_ff == CMD_READ) begin
               rkey_in = sk_rdata_ff;
               state_in = S_ROOT;
            end else begin
               sn_we = 1'b1; sk_we = 1'b1; ns_we = 1'b1;
               state_in = S_CUR;
            end
         end
         S_CUR: begin
            // choose parent if not root, else left child
            if (cur_w > cnt_type'(base_ff)) begin
               nbr_in = par_w[IdWidth-1:0];
               up_in = 1'b1;
               sk_raddr = par_w[IdWidth-1:0];
               sn_raddr = par_w[IdWidth-1:0];
               state_in = S_NBR;
            end else if (lc_w < end_w) begin
               nbr_in = lc_w[IdWidth-1:0];
               up_in = 1'b0;
               rok_in = rc_w < end_w;
               sk_raddr = lc_w[IdWidth-1:0];
               sn_raddr = lc_w[IdWidth-1:0];
               state_in = S_NBR;
            end else begin
               state_in = S_ROOT;
            end
         end
         S_NBR: begin
            nkey_in = sk_rdata_ff;
            nnode_in = sn_rdata_ff;
            if (up_ff) begin
               if (sk_rdata_ff > key_ff) state_in = S_DEC;
               else if (lc_w < end_w) begin
                  // parent fine: look downward
                  nbr_in = lc_w[IdWidth-1:0];
                  up_in = 1'b0;
                  rok_in = rc_w < end_w;
                  sk_raddr = lc_w[IdWidth-1:0];
                  sn_raddr = lc_w[IdWidth-1:0];
                  state_in = S_NBR;
               end else state_in = S_ROOT;
            end else if (rok_ff) begin
               sk_raddr = rc_w[IdWidth-1:0];
               sn_raddr = rc_w[IdWidth-1:0];
               state_in = S_RCH;
            end else if (sk_rdata_ff < key_ff) state_in = S_DEC;
            else state_in = S_ROOT;
         end
         S_RCH: begin
            // left child held in nkey/nnode
            if (sk_rdata_ff < nkey_ff && sk_rdata_ff < key_ff) begin
               nbr_in = rc_w[IdWidth-1:0];
               nkey_in = sk_rdata_ff;
               nnode_in = sn_rdata_ff;
               state_in = S_DEC;
            end else if (nkey_ff < key_ff) state_in = S_DEC;
            else state_in = S_ROOT;
         end
         S_DEC: begin
            // swap: neighbor entry moves into cur, moving entry goes to nbr
            sn_we = 1'b1; sk_we = 1'b1; ns_we = 1'b1;
            sn_wdata = nnode_ff; sk_wdata = nkey_ff;
            ns_waddr = nnode_ff; ns_wdata = cur_ff;
            cur_in = nbr_ff;
            state_in = S_POS;
         end
         S_ROOT: begin
            sn_raddr = IdWidth'(base_ff);
            sk_raddr = IdWidth'(base_ff);
            state_in = S_OUT;
         end
         S_OUT: begin
            // keep the root addressed so the read data holds while waiting
            sn_raddr = IdWidth'(base_ff);
            sk_raddr = IdWidth'(base_ff);
            if (!rsp_valid_ff || rsp_ready) begin
               empty_in = (count_ff == '0);
               min_node_in = empty_in ? '0 : sn_rdata_ff;
               min_key_in  = empty_in ? '0 : sk_rdata_ff;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // base change empties the heap; the user must write it only while idle, the block does not enforce it
      if (csr_we) begin
         base_in = csr_wdata;
         count_in = '0;
         sweep_in = '0;
         state_in = S_CLEAR;
      end
   end

   // a base-change sweep must not emit a result
   logic sweep_silent_ff, sweep_silent_in;
   always_comb begin
      sweep_silent_in = sweep_silent_ff;
      if (csr_we) sweep_silent_in = 1'b1;
      else if (state_ff == S_IDLE && req_valid && req_ready) sweep_silent_in = 1'b0;
   end

   state_type state_next;
   assign state_next = (state_ff == S_CLEAR && state_in == S_ROOT && sweep_silent_ff)
                       ? S_IDLE : state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         sweep_silent_ff <= 1'b1;
         base_ff <= 1'b0;
         count_ff <= '0;
         sweep_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_next;
         sweep_silent_ff <= sweep_silent_in;
         base_ff <= base_in;
         count_ff <= count_in;
         sweep_ff <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;     id_ff <= id_in;       key_ff <= key_in;
      cur_ff <= cur_in;     nbr_ff <= nbr_in;     nnode_ff <= nnode_in;
      nkey_ff <= nkey_in;   up_ff <= up_in;       rok_ff <= rok_in;
      min_node_ff <= min_node_in; min_key_ff <= min_key_in;
      empty_ff <= empty_in; rkey_ff <= rkey_in;   status_ff <= status_in;
   end

   // result registers hold until their transfer, so a new command waits for it
   assign req_ready      = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_min_node   = min_node_ff;
   assign rsp_min_key    = min_key_ff;
   assign rsp_heap_empty = empty_ff;
   assign rsp_read_key   = rkey_ff;
   assign rsp_status     = status_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cnt_type'(MaxNodes)) else $error("entry count overflow");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_min_key))
      else $error("result dropped while stalled");
   a_empty_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_heap_empty |-> rsp_min_key == '0 && rsp_min_node == '0)
      else $error("empty heap reports an entry");
endmodule
`default_nettype wire
